@@ rtl/mkme_pkg.sv @@
package mkme_pkg;

   localparam int FIELD_WIDTH    = 32;
   localparam int MODE_WIDTH     = 2;
   localparam int CSR_INDEX_BITS = 1;

   // occurrence_mode decode: high bit selects all mode, low bit last mode
   localparam int MODE_LAST_BIT = 0;
   localparam int MODE_ALL_BIT  = 1;

   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_OCCURRENCE_MODE,
      CSR_QUERY_KEY
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_ENTRY,
      OP_MAP_END,
      OP_NULL_MAP
   } op_type;

   typedef struct packed {
      logic                   map_null;
      logic                   entry_present;
      logic [FIELD_WIDTH-1:0] entry_key;
      logic                   key_valid;
      logic [FIELD_WIDTH-1:0] entry_item;
      logic                   entry_item_valid;
      logic                   last_entry;
   } req_beat_type;

   typedef struct packed {
      logic                   has_item;
      logic [FIELD_WIDTH-1:0] out_item;
      logic                   out_item_valid;
      logic                   result_null;
      logic                   map_done;
   } rsp_beat_type;

   typedef struct packed {
      op_type                 op;
      logic                   hit;
      logic [FIELD_WIDTH-1:0] item;
      logic                   item_valid;
      logic                   last;
   } queue_entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

@@ rtl/mkme_front.sv @@
module mkme_front #(
   parameter int KEY_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [mkme_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mkme_pkg::FIELD_WIDTH-1:0]      csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  mkme_pkg::req_beat_type                req_beat,
   input  mkme_pkg::queue_status_type            q_status,
   output logic                                  push,
   output mkme_pkg::queue_entry_type             push_entry,
   output logic [mkme_pkg::MODE_WIDTH-1:0]       occurrence_mode
);

   localparam int KeyBits = (KEY_WIDTH < mkme_pkg::FIELD_WIDTH) ?
                            KEY_WIDTH : mkme_pkg::FIELD_WIDTH;

   logic [mkme_pkg::MODE_WIDTH-1:0]  mode_ff;
   logic [mkme_pkg::FIELD_WIDTH-1:0] search_key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= '0;
         search_key_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            mkme_pkg::CSR_OCCURRENCE_MODE: mode_ff <= csr_wdata[mkme_pkg::MODE_WIDTH-1:0];
            mkme_pkg::CSR_QUERY_KEY:       search_key_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign occurrence_mode = mode_ff;
   assign req_stall       = q_status.full;
   assign push            = req_valid && !q_status.full;

   always_comb begin
      push_entry.hit = req_beat.key_valid &&
                       (req_beat.entry_key[KeyBits-1:0] == search_key_ff[KeyBits-1:0]);
      push_entry.item       = req_beat.entry_item;
      push_entry.item_valid = req_beat.entry_item_valid;
      push_entry.last       = req_beat.last_entry;
      if (req_beat.map_null) begin
         push_entry.op = mkme_pkg::OP_NULL_MAP;
      end else if (!req_beat.entry_present) begin
         push_entry.op = mkme_pkg::OP_MAP_END;
      end else begin
         push_entry.op = mkme_pkg::OP_ENTRY;
      end
   end

endmodule

@@ rtl/mkme_queue.sv @@
module mkme_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  mkme_pkg::queue_entry_type   push_entry,
   input  logic                        pop,
   output mkme_pkg::queue_entry_type   head_entry,
   output mkme_pkg::queue_status_type  q_status
);

   mkme_pkg::queue_entry_type            slot_ff [mkme_pkg::Q_DEPTH];
   logic [mkme_pkg::Q_PTR_BITS-1:0]      wr_ptr_ff;
   logic [mkme_pkg::Q_PTR_BITS-1:0]      rd_ptr_ff;
   logic [mkme_pkg::Q_CNT_BITS-1:0]      count_ff;
   logic [mkme_pkg::Q_PTR_BITS-1:0]      wr_ptr_in;
   logic [mkme_pkg::Q_PTR_BITS-1:0]      rd_ptr_in;
   logic [mkme_pkg::Q_CNT_BITS-1:0]      count_in;

   localparam logic [mkme_pkg::Q_PTR_BITS-1:0] LastSlot =
      mkme_pkg::Q_PTR_BITS'(mkme_pkg::Q_DEPTH - 1);
   localparam logic [mkme_pkg::Q_CNT_BITS-1:0] FullCount =
      mkme_pkg::Q_CNT_BITS'(mkme_pkg::Q_DEPTH);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastSlot) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastSlot) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry     = slot_ff[rd_ptr_ff];
   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == FullCount);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCount)
      else $error("queue count beyond depth");

endmodule

@@ rtl/mkme_back.sv @@
module mkme_back #(
   parameter int ITEM_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [mkme_pkg::MODE_WIDTH-1:0]   occurrence_mode,
   input  mkme_pkg::queue_status_type        q_status,
   input  mkme_pkg::queue_entry_type         head_entry,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output mkme_pkg::rsp_beat_type            rsp_beat
);

   localparam int ItemBits = (ITEM_WIDTH < mkme_pkg::FIELD_WIDTH) ?
                             ITEM_WIDTH : mkme_pkg::FIELD_WIDTH;

   logic                    match_seen_ff, match_seen_in;
   logic [ItemBits-1:0]     held_item_ff, held_item_in;
   logic                    held_valid_ff, held_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   mkme_pkg::rsp_beat_type  rsp_beat_ff, rsp_beat_in;
   logic                    emit;
   logic                    all_mode;
   logic                    last_mode;

   assign all_mode  = occurrence_mode[mkme_pkg::MODE_ALL_BIT];
   assign last_mode = occurrence_mode[mkme_pkg::MODE_LAST_BIT];
   assign pop       = !q_status.empty && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      logic                take_hit;
      logic                sel_seen;
      logic [ItemBits-1:0] sel_item;
      logic                sel_valid;
      logic [ItemBits-1:0] new_item;

      new_item  = head_entry.item[ItemBits-1:0];
      take_hit  = head_entry.hit && (last_mode || !match_seen_ff);
      sel_seen  = match_seen_ff || take_hit;
      sel_item  = take_hit ? new_item : held_item_ff;
      sel_valid = take_hit ? head_entry.item_valid : held_valid_ff;

      match_seen_in = match_seen_ff;
      held_item_in  = held_item_ff;
      held_valid_in = held_valid_ff;
      emit          = 1'b0;
      rsp_beat_in   = '0;

      case (head_entry.op)
         mkme_pkg::OP_NULL_MAP: begin
            emit                    = 1'b1;
            rsp_beat_in.result_null = 1'b1;
            rsp_beat_in.map_done    = 1'b1;
            match_seen_in           = 1'b0;
            held_item_in            = '0;
            held_valid_in           = 1'b0;
         end
         mkme_pkg::OP_MAP_END: begin
            emit                       = 1'b1;
            rsp_beat_in.has_item       = !all_mode && match_seen_ff;
            rsp_beat_in.out_item       = mkme_pkg::FIELD_WIDTH'(held_item_ff);
            rsp_beat_in.out_item_valid = held_valid_ff;
            rsp_beat_in.result_null    = !match_seen_ff;
            rsp_beat_in.map_done       = 1'b1;
            match_seen_in              = 1'b0;
            held_item_in               = '0;
            held_valid_in              = 1'b0;
         end
         mkme_pkg::OP_ENTRY: begin
            if (all_mode) begin
               // stream every match; the closing marker merges into a match on the last entry
               if (head_entry.hit) begin
                  emit                       = 1'b1;
                  rsp_beat_in.has_item       = 1'b1;
                  rsp_beat_in.out_item       = mkme_pkg::FIELD_WIDTH'(new_item);
                  rsp_beat_in.out_item_valid = head_entry.item_valid;
                  rsp_beat_in.map_done       = head_entry.last;
                  match_seen_in              = !head_entry.last;
               end else if (head_entry.last) begin
                  emit                    = 1'b1;
                  rsp_beat_in.result_null = !match_seen_ff;
                  rsp_beat_in.map_done    = 1'b1;
                  match_seen_in           = 1'b0;
               end
               if (head_entry.last) begin
                  held_item_in  = '0;
                  held_valid_in = 1'b0;
               end
            end else if (head_entry.last) begin
               emit                       = 1'b1;
               rsp_beat_in.has_item       = sel_seen;
               rsp_beat_in.out_item       = mkme_pkg::FIELD_WIDTH'(sel_item);
               rsp_beat_in.out_item_valid = sel_valid;
               rsp_beat_in.result_null    = !sel_seen;
               rsp_beat_in.map_done       = 1'b1;
               match_seen_in              = 1'b0;
               held_item_in               = '0;
               held_valid_in              = 1'b0;
            end else begin
               match_seen_in = sel_seen;
               held_item_in  = sel_item;
               held_valid_in = sel_valid;
            end
         end
         default: ;
      endcase

      // no item, no payload
      if (!rsp_beat_in.has_item) begin
         rsp_beat_in.out_item       = '0;
         rsp_beat_in.out_item_valid = 1'b0;
      end

      if (pop && emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_seen_ff <= 1'b0;
         held_item_ff  <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            match_seen_ff <= match_seen_in;
            held_item_ff  <= held_item_in;
            held_valid_ff <= held_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         rsp_beat_ff <= rsp_beat_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

   a_null_has_no_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_beat_ff.result_null && rsp_beat_ff.has_item))
      else $error("null result carries an item");

   a_empty_item_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_beat_ff.has_item) |->
         (rsp_beat_ff.out_item == '0 && !rsp_beat_ff.out_item_valid))
      else $error("result without item has nonzero payload");

   a_done_clears_state: assert property (@(posedge clock) disable iff (reset)
      (pop && emit && rsp_beat_in.map_done) |=> !match_seen_ff)
      else $error("map state survives map end");

endmodule

@@ rtl/map_key_match_extractor.sv @@
// Map key match extractor: takes one map entry beat per cycle on req_ while
// req_stall is low and compares its key (low KEY_WIDTH bits) against the
// search key register. In first or last mode (csr occurrence_mode 0 or 1)
// one result beat leaves on rsp_ when the map closes (last_entry, an
// empty-map beat or a null-map beat); in all mode (2 or 3) every matching
// entry leaves as a beat and a closing marker follows at map end, merged
// into the match when the last entry matches. Throughput is one beat per
// cycle while req_stall is low, with the single key compare in the front
// stage and the match state update in the back stage. The beat that closes
// a map is written into the four-entry queue, and its result then passes
// the match state into the output register. The queue lets the front keep
// taking beats under rsp_stall until it is full and req_stall rises. Write
// the registers only while no beats are in flight.
module map_key_match_extractor #(
   parameter int KEY_WIDTH  = 32,
   parameter int ITEM_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [mkme_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mkme_pkg::FIELD_WIDTH-1:0]    csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mkme_pkg::req_beat_type              req_beat,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mkme_pkg::rsp_beat_type              rsp_beat
);

   mkme_pkg::queue_status_type        q_status;
   mkme_pkg::queue_entry_type         push_entry;
   mkme_pkg::queue_entry_type         head_entry;
   logic                              push;
   logic                              pop;
   logic [mkme_pkg::MODE_WIDTH-1:0]   occurrence_mode;

   // Front: hold config, classify each beat and resolve the key match
   mkme_front #(
      .KEY_WIDTH (KEY_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_beat        (req_beat),
      .q_status        (q_status),
      .push            (push),
      .push_entry      (push_entry),
      .occurrence_mode (occurrence_mode)
   );

   // Queue: decouple the classifier from result delivery
   mkme_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   // Back: advance the per-map match state and drive the result register
   mkme_back #(
      .ITEM_WIDTH (ITEM_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .occurrence_mode (occurrence_mode),
      .q_status        (q_status),
      .head_entry      (head_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_beat        (rsp_beat)
   );

endmodule

@@ sim/tb.sv @@
module tb;

   // occurrence_mode codes: the high bit selects all mode, so 3 acts as all mode too
   localparam logic [1:0] MODE_FIRST    = 2'd0;
   localparam logic [1:0] MODE_LAST     = 2'd1;
   localparam logic [1:0] MODE_ALL      = 2'd2;
   localparam logic [1:0] MODE_ALL_HIGH = 2'd3;

   localparam int RANDOM_BEATS = 1450;
   // Cycles to let a result-free beat leave the pipe before a register write
   localparam int SETTLE_CYCLES = 12;
   localparam int END_WAIT_LIMIT = 5000;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_we;
   mkme_pkg::csr_index_type csr_index;
   logic [31:0]             csr_wdata;
   logic                    req_valid;
   logic                    req_stall;
   mkme_pkg::req_beat_type  req_beat;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   mkme_pkg::rsp_beat_type  rsp_beat;

   map_key_match_extractor u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mirror of the block: register copies plus the open-map match state
   logic [1:0]  cfg_mode = MODE_FIRST;
   logic [31:0] cfg_key = '0;
   bit          open_match_seen = 1'b0;
   logic [31:0] open_held_item = '0;
   bit          open_held_valid = 1'b0;

   mkme_pkg::rsp_beat_type pending_map_results[$];

   int beats_sent = 0;
   int results_checked = 0;
   int items_returned = 0;
   int settings_written = 0;
   int fail_count = 0;
   bit sender_burst = 1'b0;
   int stall_left = 0;
   int calm_left = 0;

   typedef struct {
      logic [1:0]             mode;
      logic [31:0]            qkey;
      mkme_pkg::req_beat_type beat;
      bit                     typed;
      mkme_pkg::rsp_beat_type want;
   } plan_row_type;

   plan_row_type directed_rows[$];

   function automatic mkme_pkg::req_beat_type mk_beat(
      bit map_null, bit present, logic [31:0] key, bit kvalid, logic [31:0] item,
      bit ivalid, bit last);
      mkme_pkg::req_beat_type b;
      b.map_null         = map_null;
      b.entry_present    = present;
      b.entry_key        = key;
      b.key_valid        = kvalid;
      b.entry_item       = item;
      b.entry_item_valid = ivalid;
      b.last_entry       = last;
      return b;
   endfunction

   function automatic mkme_pkg::rsp_beat_type mk_rsp(bit has, logic [31:0] item, bit ivalid,
                                                     bit is_null, bit done);
      mkme_pkg::rsp_beat_type r;
      r.has_item       = has;
      r.out_item       = item;
      r.out_item_valid = ivalid;
      r.result_null    = is_null;
      r.map_done       = done;
      return r;
   endfunction

   function automatic void add_row(logic [1:0] mode, logic [31:0] qkey,
                                   mkme_pkg::req_beat_type beat, bit typed = 1'b0,
                                   mkme_pkg::rsp_beat_type want = '0);
      plan_row_type row;
      row.mode  = mode;
      row.qkey  = qkey;
      row.beat  = beat;
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endfunction

   function automatic string beat_text(mkme_pkg::rsp_beat_type b);
      return $sformatf("has_item=%0b item=%08h item_valid=%0b null=%0b done=%0b",
                       b.has_item, b.out_item, b.out_item_valid, b.result_null, b.map_done);
   endfunction

   // Only the first ten failures get a line; the rest are just counted
   function automatic void log_failure(string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("%s", msg);
   endfunction

   function automatic void clear_open_map();
      open_match_seen = 1'b0;
      open_held_item  = '0;
      open_held_valid = 1'b0;
   endfunction

   // Work out the result (if any) that one accepted request beat causes, and
   // advance the mirrored map state.
   function automatic bit predict_map_result(input mkme_pkg::req_beat_type b,
                                             output mkme_pkg::rsp_beat_type r);
      bit all_mode;
      bit last_mode;
      bit hit;
      all_mode  = cfg_mode[mkme_pkg::MODE_ALL_BIT];
      last_mode = cfg_mode[mkme_pkg::MODE_LAST_BIT];
      r = '0;
      // Null map: drop whatever was open, give a null closing result
      if (b.map_null) begin
         clear_open_map();
         r.result_null = 1'b1;
         r.map_done    = 1'b1;
         return 1'b1;
      end
      // No entry carried: close the map regardless of last_entry
      if (!b.entry_present) begin
         r.map_done    = 1'b1;
         r.result_null = !open_match_seen;
         if (!all_mode && open_match_seen) begin
            r.has_item       = 1'b1;
            r.out_item       = open_held_item;
            r.out_item_valid = open_held_valid;
         end
         clear_open_map();
         return 1'b1;
      end
      hit = b.key_valid && (b.entry_key == cfg_key);
      if (all_mode) begin
         // A match on the last entry folds the closing marker into the match
         if (hit) begin
            open_match_seen  = 1'b1;
            r.has_item       = 1'b1;
            r.out_item       = b.entry_item;
            r.out_item_valid = b.entry_item_valid;
            r.map_done       = b.last_entry;
            if (b.last_entry)
               clear_open_map();
            return 1'b1;
         end
         if (b.last_entry) begin
            r.result_null = !open_match_seen;
            r.map_done    = 1'b1;
            clear_open_map();
            return 1'b1;
         end
         return 1'b0;
      end
      if (hit && (last_mode || !open_match_seen)) begin
         open_held_item  = b.entry_item;
         open_held_valid = b.entry_item_valid;
         open_match_seen = 1'b1;
      end
      if (b.last_entry) begin
         r.has_item    = open_match_seen;
         if (open_match_seen) begin
            r.out_item       = open_held_item;
            r.out_item_valid = open_held_valid;
         end
         r.result_null = !open_match_seen;
         r.map_done    = 1'b1;
         clear_open_map();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void check_result(mkme_pkg::rsp_beat_type got);
      mkme_pkg::rsp_beat_type want;
      if (pending_map_results.size() == 0) begin
         log_failure({"unexpected result beat: ", beat_text(got)});
         return;
      end
      want = pending_map_results.pop_front();
      results_checked++;
      if (got.has_item)
         items_returned++;
      if (got.has_item !== want.has_item || got.out_item !== want.out_item ||
          got.out_item_valid !== want.out_item_valid ||
          got.result_null !== want.result_null || got.map_done !== want.map_done)
         log_failure($sformatf("result %0d mismatch: expected %s, got %s",
                               results_checked, beat_text(want), beat_text(got)));
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Result side: take a beat whenever valid is high and we are not stalling,
   // then pick the stall for the next cycle. Calm stretches leave the stall low.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         check_result(rsp_beat);
      if (stall_left > 0)
         stall_left--;
      else if (calm_left > 0)
         calm_left--;
      else if ($urandom_range(0, 19) == 0)
         calm_left = $urandom_range(40, 160);
      else
         stall_left = pick_gap();
      rsp_stall <= (stall_left > 0);
   end

   // Present one beat, hold it until taken, predict, then idle for a random gap (none in burst mode)
   task automatic send_beat(input mkme_pkg::req_beat_type b, input bit typed = 1'b0,
                            input mkme_pkg::rsp_beat_type want = '0);
      mkme_pkg::rsp_beat_type predicted;
      bit                     produces;
      int                     gap;
      req_valid <= 1'b1;
      req_beat  <= b;
      do
         @(posedge clock);
      while (req_stall);
      beats_sent++;
      produces = predict_map_result(b, predicted);
      if (typed)
         pending_map_results.push_back(want);
      else if (produces)
         pending_map_results.push_back(predicted);
      gap = sender_burst ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold the sender until every expected result is back, then let the pipe settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_map_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers; junk in the unused mode bits must be dropped
   task automatic write_settings(input logic [1:0] mode, input logic [31:0] key);
      logic [31:0] mode_word;
      mode_word      = $urandom();
      mode_word[1:0] = mode;
      csr_we    <= 1'b1;
      csr_index <= mkme_pkg::CSR_OCCURRENCE_MODE;
      csr_wdata <= mode_word;
      @(posedge clock);
      cfg_mode = mode;
      csr_index <= mkme_pkg::CSR_QUERY_KEY;
      csr_wdata <= key;
      @(posedge clock);
      cfg_key = key;
      csr_we <= 1'b0;
      settings_written++;
   endtask

   function automatic logic [31:0] random_item();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic mkme_pkg::req_beat_type random_entry(bit last);
      logic [31:0] key;
      int          r;
      r = $urandom_range(0, 99);
      if (r < 40)
         key = cfg_key;
      else if (r < 55)
         key = cfg_key ^ (32'd1 << $urandom_range(0, 31));
      else
         key = random_item();
      return mk_beat(1'b0, 1'b1, key, $urandom_range(0, 99) < 85, random_item(),
                     $urandom_range(0, 99) < 80, last);
   endfunction

   // Null-map or empty-map beat with every other field random
   function automatic mkme_pkg::req_beat_type random_closer(bit as_null);
      mkme_pkg::req_beat_type b;
      b = mk_beat(as_null, as_null ? 1'($urandom_range(0, 1)) : 1'b0, $urandom(),
                  1'($urandom_range(0, 1)), $urandom(), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      return b;
   endfunction

   // Mostly well-formed maps; some null or empty slots, some maps cut short
   task automatic send_random_map();
      int kind;
      int n;
      kind = $urandom_range(0, 99);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
      if (kind < 6) begin
         send_beat(random_closer(1'b1));
      end else if (kind < 12) begin
         send_beat(random_closer(1'b0));
      end else begin
         for (int i = 0; i < n; i++) begin
            send_beat(random_entry((i == n - 1) && (kind >= 18)));
            // occasional drain mid-map
            if ($urandom_range(0, 199) == 0)
               wait_idle();
         end
         if (kind < 18)
            send_beat(random_closer(1'($urandom_range(0, 1))));
      end
   endtask

   initial begin
      #(6_000_000);
      $display("[map_key_match_extractor] ERROR");
      $finish;
   end

   initial begin
      logic [1:0]  phase_mode;
      logic [31:0] phase_key;
      int          phase;
      int          phase_end;
      int          random_target;
      int          waited;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_beat  <= '0;
      csr_we    <= 1'b0;
      csr_index <= mkme_pkg::CSR_OCCURRENCE_MODE;
      csr_wdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed rows. Reset settings first: null map, empty map, first-mode hold,
      // null key on the last entry.
      add_row(MODE_FIRST, '0, mk_beat(1, 0, '0, 0, '0, 0, 0), 1, mk_rsp(0, '0, 0, 1, 1));
      add_row(MODE_FIRST, '0, mk_beat(0, 0, '0, 0, '0, 0, 0), 1, mk_rsp(0, '0, 0, 1, 1));
      add_row(MODE_FIRST, '0, mk_beat(0, 1, '0, 1, '1, 1, 0));
      add_row(MODE_FIRST, '0, mk_beat(0, 1, '0, 1, 32'd5, 1, 1), 1, mk_rsp(1, '1, 1, 0, 1));
      add_row(MODE_FIRST, '0, mk_beat(0, 1, '0, 0, 32'd9, 1, 1), 1, mk_rsp(0, '0, 0, 1, 1));
      // Last mode, all-ones key: a null matched item, a null map dropping an open
      // map, an empty-map beat closing an open map
      add_row(MODE_LAST, '1, mk_beat(0, 1, '1, 1, 32'd1, 1, 0));
      add_row(MODE_LAST, '1, mk_beat(0, 1, '1, 1, 32'd2, 0, 0));
      add_row(MODE_LAST, '1, mk_beat(0, 1, '0, 1, 32'd3, 1, 1), 1, mk_rsp(1, 32'd2, 0, 0, 1));
      add_row(MODE_LAST, '1, mk_beat(0, 1, '1, 1, 32'd7, 1, 0));
      add_row(MODE_LAST, '1, mk_beat(1, 1, '1, 1, '1, 1, 1), 1, mk_rsp(0, '0, 0, 1, 1));
      add_row(MODE_LAST, '1, mk_beat(0, 1, '1, 1, 32'd7, 1, 0));
      add_row(MODE_LAST, '1, mk_beat(0, 0, '1, 1, '0, 0, 0), 1, mk_rsp(1, 32'd7, 1, 0, 1));
      // All mode: streamed match, silent miss, non-null and null markers, merged close
      add_row(MODE_ALL, 32'h5a5a_5a5a, mk_beat(0, 1, 32'h5a5a_5a5a, 1, 32'ha5a5_a5a5, 1, 0),
              1, mk_rsp(1, 32'ha5a5_a5a5, 1, 0, 0));
      add_row(MODE_ALL, 32'h5a5a_5a5a, mk_beat(0, 1, 32'h5a5a_5a5b, 1, 32'd4, 1, 0));
      add_row(MODE_ALL, 32'h5a5a_5a5a, mk_beat(0, 1, '0, 1, 32'd4, 1, 1),
              1, mk_rsp(0, '0, 0, 0, 1));
      add_row(MODE_ALL, 32'h5a5a_5a5a, mk_beat(0, 1, 32'h5a5a_5a5a, 0, 32'd4, 1, 1),
              1, mk_rsp(0, '0, 0, 1, 1));
      add_row(MODE_ALL, 32'h5a5a_5a5a, mk_beat(0, 1, 32'h5a5a_5a5a, 1, '0, 1, 1),
              1, mk_rsp(1, '0, 1, 0, 1));
      // Mode 3 behaves as all mode
      add_row(MODE_ALL_HIGH, 32'h8000_0001,
              mk_beat(0, 1, 32'h8000_0001, 1, 32'h1234_5678, 0, 0),
              1, mk_rsp(1, 32'h1234_5678, 0, 0, 0));
      add_row(MODE_ALL_HIGH, 32'h8000_0001, mk_beat(0, 0, '0, 0, '0, 0, 0),
              1, mk_rsp(0, '0, 0, 0, 1));
      add_row(MODE_ALL_HIGH, 32'h8000_0001, mk_beat(0, 0, '0, 0, '0, 0, 1),
              1, mk_rsp(0, '0, 0, 1, 1));
      add_row(MODE_ALL_HIGH, 32'h8000_0001, mk_beat(0, 1, 32'h8000_0001, 1, '1, 1, 1));
      // First mode keeps the first of several matches
      add_row(MODE_FIRST, '1, mk_beat(0, 1, '1, 1, 32'd1, 1, 0));
      add_row(MODE_FIRST, '1, mk_beat(0, 1, '1, 1, 32'd2, 1, 0));
      add_row(MODE_FIRST, '1, mk_beat(0, 1, 32'd1, 1, 32'd3, 1, 1));

      // Walk the table; change registers only between maps, with the pipe drained
      foreach (directed_rows[i]) begin
         if (directed_rows[i].mode != cfg_mode || directed_rows[i].qkey != cfg_key) begin
            wait_idle();
            write_settings(directed_rows[i].mode, directed_rows[i].qkey);
         end
         send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
      end

      // Random phases: each starts from idle with fresh register settings
      random_target = beats_sent + RANDOM_BEATS;
      phase = 0;
      while (beats_sent < random_target) begin
         case (phase)
            0: begin
               phase_mode = MODE_FIRST;
               phase_key  = '0;
            end
            1: begin
               phase_mode = MODE_ALL_HIGH;
               phase_key  = '1;
            end
            2: begin
               phase_mode = MODE_LAST;
               phase_key  = $urandom();
            end
            3: begin
               phase_mode = MODE_ALL;
               phase_key  = $urandom();
            end
            default: begin
               phase_mode = 2'($urandom_range(0, 3));
               case ($urandom_range(0, 4))
                  0: phase_key = '0;
                  1: phase_key = '1;
                  default: phase_key = $urandom();
               endcase
            end
         endcase
         wait_idle();
         write_settings(phase_mode, phase_key);
         sender_burst = ($urandom_range(0, 3) == 0);
         phase_end = beats_sent + $urandom_range(60, 180);
         while (beats_sent < phase_end && beats_sent < random_target)
            send_random_map();
         phase++;
      end
      req_valid <= 1'b0;

      // Drain, with a bound so a lost result shows as leftover, not a hang
      waited = 0;
      while (pending_map_results.size() != 0 && waited < END_WAIT_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      while (pending_map_results.size() != 0)
         log_failure({"result never arrived: ", beat_text(pending_map_results.pop_front())});

      $display("Sent %0d request beats under %0d register settings; checked %0d results,",
               beats_sent, settings_written, results_checked);
      $display("%0d of them carrying a matched item, %0d failures.",
               items_returned, fail_count);
      if (fail_count == 0)
         $display("[map_key_match_extractor] OK");
      else
         $display("[map_key_match_extractor] ERROR");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/mkme_pkg.sv
rtl/mkme_front.sv
rtl/mkme_queue.sv
rtl/mkme_back.sv
rtl/map_key_match_extractor.sv
sim/tb.sv
